[design/ombag_pkg.sv]
// ----------------------------------------------------------------------------
// ombag_pkg
// Shared types and opcodes of the insertion-ordered multiset.
// ----------------------------------------------------------------------------
package ombag_pkg;

  localparam logic [2:0] OP_VALUE     = 3'd0;
  localparam logic [2:0] OP_SET_FLAG  = 3'd1;
  localparam logic [2:0] OP_VALUE_FLG = 3'd2;
  localparam logic [2:0] OP_DUMP      = 3'd3;
  localparam logic [2:0] OP_CUT       = 3'd4;
  localparam logic [2:0] OP_LENGTH    = 3'd5;
  localparam logic [2:0] OP_CLEAR     = 3'd6;

  localparam logic [1:0] REG_ALLOW_DUP = 2'd0;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [DataW-1:0] value;
    logic                    flag;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] result_value;
    logic                    last;
  } res_t;

endpackage

[design/ombag_mem.sv]
// ----------------------------------------------------------------------------
// ombag_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ombag_mem
  import ombag_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/ombag_ctrl.sv]
// ----------------------------------------------------------------------------
// ombag_ctrl
// Sequencer: runs search, gap close, dump and cut over the entry store.
// ----------------------------------------------------------------------------
module ombag_ctrl
  import ombag_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd_i,
  input  logic             allow_dup_i,
  output logic             result_strobe_o,
  output res_t             res_o,
  output logic             we_o,
  output logic [AW-1:0]    waddr_o,
  output logic [DataW-1:0] wdata_o,
  output logic [AW-1:0]    raddr_o,
  input  logic [DataW-1:0] rdata_i
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCNUP = 6'b000010,
    ST_SCNDN = 6'b000100,
    ST_SHIFT = 6'b001000,
    ST_CUT   = 6'b010000,
    ST_DUMP  = 6'b100000
  } state_e;

  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic             mode_q, mode_d;
  logic             pend_q, pend_d;
  logic             strobe_q, strobe_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [AW-1:0]    rd_addr_q, rd_addr_d;
  logic [DataW-1:0] val_q, val_d;
  res_t             res_q, res_d;

  logic [CW-1:0]    ptr_dec;
  logic             match;
  logic             eff_mode;

  assign ptr_dec  = ptr_q - 1'b1;
  assign match    = pend_q && (rdata_i == val_q);
  assign eff_mode = (cmd_i.opcode == OP_VALUE_FLG) ? cmd_i.flag : mode_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    mode_d    = mode_q;
    pend_d    = 1'b0;
    strobe_d  = 1'b0;
    ptr_d     = ptr_q;
    rd_addr_d = rd_addr_q;
    val_d     = val_q;
    res_d     = '{result_value: rdata_i, last: 1'b0};
    we_o      = 1'b0;
    waddr_o   = count_q[AW-1:0];
    wdata_o   = val_q;
    raddr_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_i.opcode)
            OP_VALUE, OP_VALUE_FLG: begin
              if (cmd_i.opcode == OP_VALUE_FLG) begin
                mode_d = cmd_i.flag;
              end
              val_d = cmd_i.value;
              if (eff_mode) begin
                if (allow_dup_i) begin
                  if (count_q < CapC) begin
                    we_o    = 1'b1;
                    wdata_o = cmd_i.value;
                    count_d = count_q + 1'b1;
                  end
                end else begin
                  ptr_d   = '0;
                  state_d = ST_SCNUP;
                end
              end else begin
                ptr_d   = count_q;
                state_d = ST_SCNDN;
              end
            end
            OP_SET_FLAG: mode_d = cmd_i.flag;
            OP_DUMP: begin
              if (count_q != '0) begin
                ptr_d   = count_q;
                state_d = ST_DUMP;
              end
            end
            OP_CUT: begin
              if (count_q != '0) begin
                raddr_o = '0;
                state_d = ST_CUT;
              end
            end
            OP_LENGTH: begin
              strobe_d = 1'b1;
              res_d    = '{result_value: {{(DataW-CW){1'b0}}, count_q}, last: 1'b1};
            end
            OP_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      ST_SCNUP: begin
        if (match) begin
          state_d = ST_IDLE;
        end else if (ptr_q == count_q) begin
          state_d = ST_IDLE;
          if (count_q < CapC) begin
            we_o    = 1'b1;
            count_d = count_q + 1'b1;
          end
        end else begin
          raddr_o   = ptr_q[AW-1:0];
          rd_addr_d = ptr_q[AW-1:0];
          pend_d    = 1'b1;
          ptr_d     = ptr_q + 1'b1;
        end
      end
      ST_SCNDN: begin
        if (match) begin
          ptr_d   = CW'(rd_addr_q) + 1'b1;
          state_d = ST_SHIFT;
        end else if (ptr_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          raddr_o   = ptr_dec[AW-1:0];
          rd_addr_d = ptr_dec[AW-1:0];
          pend_d    = 1'b1;
          ptr_d     = ptr_dec;
        end
      end
      ST_CUT: begin
        strobe_d = 1'b1;
        res_d    = '{result_value: rdata_i, last: 1'b1};
        ptr_d    = CW'(1);
        state_d  = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (pend_q) begin
          we_o    = 1'b1;
          waddr_o = rd_addr_q - 1'b1;
          wdata_o = rdata_i;
        end
        if (ptr_q < count_q) begin
          raddr_o   = ptr_q[AW-1:0];
          rd_addr_d = ptr_q[AW-1:0];
          pend_d    = 1'b1;
          ptr_d     = ptr_q + 1'b1;
        end else if (!pend_q) begin
          count_d = count_q - 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (pend_q) begin
          strobe_d = 1'b1;
          res_d    = '{result_value: rdata_i, last: (rd_addr_q == '0)};
        end
        if (pend_q && rd_addr_q == '0) begin
          state_d = ST_IDLE;
        end else if (ptr_q != '0) begin
          raddr_o   = ptr_dec[AW-1:0];
          rd_addr_d = ptr_dec[AW-1:0];
          pend_d    = 1'b1;
          ptr_d     = ptr_dec;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      mode_q   <= 1'b0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    rd_addr_q <= rd_addr_d;
    val_q     <= val_d;
    res_q     <= res_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign result_strobe_o = strobe_q;
  assign res_o           = res_q;

endmodule

[design/ordered_multiset_bag_top.sv]
// ----------------------------------------------------------------------------
// ordered_multiset_bag_top
// Insertion-ordered multiset of 32-bit values with an APB config register.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the operation is done. An add without duplicates reads each live
// entry through the single store read port, a remove searches from the
// newest entry and then moves one entry per cycle, and cut and dump also
// walk the live entries. Results come one per cycle on res_o, marked by
// result_strobe_o for a single cycle, the last of an item carrying last;
// they cannot be held off, so sample every strobe. Write allow_duplicates
// (byte address 0) only while busy is low.
module ordered_multiset_bag_top
  import ombag_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  output logic        result_strobe_o,
  output res_t        res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic             allow_dup_q;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [DataW-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [DataW-1:0] rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_dup_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      allow_dup_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ALLOW_DUP) ? {31'b0, allow_dup_q} : 32'b0;

  ombag_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .allow_dup_i    (allow_dup_q),
    .result_strobe_o(result_strobe_o),
    .res_o          (res_o),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .raddr_o        (raddr),
    .rdata_i        (rdata)
  );

  ombag_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule
